>>> rtl/fpba_pkg.sv
package fpba_pkg;

   localparam int NUM_BLOCKS_DEF = 16;
   localparam int SIZE_WIDTH_DEF = 16;

   localparam int SLOT_W      = 4;
   localparam int PORT_SIZE_W = 16;
   localparam int POLICY_W    = 2;
   localparam int COUNT_W     = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_POLICY      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_COUNT = 2'd1;

   localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

   localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 5'd16;

   typedef logic [1:0] step_type;

   localparam step_type STEP_FETCH  = 2'd0;
   localparam step_type STEP_DECIDE = 2'd1;
   localparam step_type STEP_LOAD   = 2'd2;
   localparam step_type STEP_SCAN   = 2'd3;

   typedef enum logic [1:0] {
      OP_FETCH,
      OP_LOAD,
      OP_SCAN,
      OP_DECIDE
   } op_type;

   typedef enum logic [1:0] {
      C_ALWAYS,
      C_ACCEPT,
      C_SCAN_LAST,
      C_OUT_FREE
   } cond_type;

   typedef struct packed {
      logic     req_ready;
      op_type   op;
      cond_type cond;
      logic     dispatch;
      step_type t_true;
      step_type t_false;
   } ctrl_word_type;

   typedef struct packed {
      logic accept;
      logic kind;
      logic scan_last;
      logic out_free;
   } status_type;

   // The fetch step dispatches on the word's kind: the load step and the scan
   // step differ only in their lowest code bit.
   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type cw;
      unique case (step)
         STEP_FETCH:  cw = '{1'b1, OP_FETCH,  C_ACCEPT,    1'b1, STEP_LOAD,   STEP_FETCH};
         STEP_LOAD:   cw = '{1'b0, OP_LOAD,   C_ALWAYS,    1'b0, STEP_FETCH,  STEP_FETCH};
         STEP_SCAN:   cw = '{1'b0, OP_SCAN,   C_SCAN_LAST, 1'b0, STEP_DECIDE, STEP_SCAN};
         STEP_DECIDE: cw = '{1'b0, OP_DECIDE, C_OUT_FREE,  1'b0, STEP_FETCH,  STEP_DECIDE};
      endcase
      return cw;
   endfunction

endpackage

>>> rtl/fit_policy_block_allocator.sv
// A request word runs a fetch step, a scan step for each block read from the free-size
// RAM, and a write-back step that waits while a response is still held. A load word
// runs a fetch step and a load step. The response is registered in the write-back
// step; the next word is accepted while a response waits.
// Synchronous reset marks every block empty at once through per-block valid bits
// and sets the policy to first fit and the block count to 16.
module fit_policy_block_allocator #(
   parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
   parameter int SIZE_WIDTH = fpba_pkg::SIZE_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_kind,
   input  logic [fpba_pkg::SLOT_W-1:0]      req_slot,
   input  logic [fpba_pkg::PORT_SIZE_W-1:0] req_size,
   input  logic                             req_batch_last,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_granted,
   output logic [fpba_pkg::SLOT_W-1:0]      rsp_chosen_block,
   output logic [fpba_pkg::PORT_SIZE_W-1:0] rsp_size_before,
   output logic [fpba_pkg::PORT_SIZE_W-1:0] rsp_size_left,
   output logic                             rsp_batch_done,
   input  logic                             csr_write_en,
   input  logic [fpba_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fpba_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fpba_pkg::*;

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   logic [POLICY_W-1:0] policy_ff, policy_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [CMP_W-1:0]    count_ext;
   logic [CMP_W-1:0]    last_ext;
   logic [IDX_W-1:0]    last_idx;
   logic                accept;
   ctrl_word_type       ctrl;
   status_type          status;

   always_comb begin
      policy_in = policy_ff;
      count_in  = count_ff;
      if (csr_write_en) begin
         if (csr_index == CSR_POLICY) begin
            policy_in = csr_wdata[POLICY_W-1:0];
         end else if (csr_index == CSR_BLOCK_COUNT) begin
            count_in = csr_wdata[COUNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POL_FIRST;
         count_ff  <= BLOCK_COUNT_RESET;
      end else begin
         policy_ff <= policy_in;
         count_ff  <= count_in;
      end
   end

   // A count of zero scans one block; a count above the table scans all of it.
   always_comb begin
      count_ext = CMP_W'(count_ff);
      priority if (count_ext == '0) begin
         last_ext = '0;
      end else if (count_ext > CMP_W'(NUM_BLOCKS)) begin
         last_ext = CMP_W'(NUM_BLOCKS - 1);
      end else begin
         last_ext = count_ext - 1'b1;
      end
      last_idx = last_ext[IDX_W-1:0];
   end

   assign req_ready = ctrl.req_ready;
   assign accept    = req_valid && ctrl.req_ready;

   fpba_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   fpba_datapath #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_WIDTH (SIZE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .policy           (policy_ff),
      .last_idx         (last_idx),
      .accept           (accept),
      .req_kind         (req_kind),
      .req_slot         (req_slot),
      .req_size         (req_size),
      .req_batch_last   (req_batch_last),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_granted      (rsp_granted),
      .rsp_chosen_block (rsp_chosen_block),
      .rsp_size_before  (rsp_size_before),
      .rsp_size_left    (rsp_size_left),
      .rsp_batch_done   (rsp_batch_done),
      .status           (status)
   );

`ifndef SYNTH
   a_rsp_from_decide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctrl.op == OP_DECIDE))
      else $error("response raised outside the write-back step");

   a_request_scans: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind) |=> (ctrl.op == OP_SCAN))
      else $error("accepted request did not start a scan");

   a_refusal_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_granted) |->
         (rsp_chosen_block == '0 && rsp_size_before == '0 && rsp_size_left == '0))
      else $error("refused response carries nonzero fields");
`endif

endmodule

>>> rtl/fpba_ram.sv
module fpba_ram #(
   parameter int WIDTH = fpba_pkg::SIZE_WIDTH_DEF,
   parameter int DEPTH = fpba_pkg::NUM_BLOCKS_DEF,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/fpba_seq.sv
module fpba_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  fpba_pkg::status_type    status,
   output fpba_pkg::ctrl_word_type ctrl
);
   import fpba_pkg::*;

   step_type step_ff;
   step_type step_in;
   logic     cond_true;
   step_type target;

   assign ctrl = ucode_rom(step_ff);

   always_comb begin
      unique case (ctrl.cond)
         C_ALWAYS:    cond_true = 1'b1;
         C_ACCEPT:    cond_true = status.accept;
         C_SCAN_LAST: cond_true = status.scan_last;
         C_OUT_FREE:  cond_true = status.out_free;
      endcase
      target = cond_true ? ctrl.t_true : ctrl.t_false;
      if (cond_true && ctrl.dispatch) begin
         target = target | {1'b0, status.kind};
      end
      step_in = target;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

>>> rtl/fpba_datapath.sv
module fpba_datapath #(
   parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
   parameter int SIZE_WIDTH = fpba_pkg::SIZE_WIDTH_DEF,
   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  fpba_pkg::ctrl_word_type          ctrl,
   input  logic [fpba_pkg::POLICY_W-1:0]    policy,
   input  logic [IDX_W-1:0]                 last_idx,
   input  logic                             accept,
   input  logic                             req_kind,
   input  logic [fpba_pkg::SLOT_W-1:0]      req_slot,
   input  logic [fpba_pkg::PORT_SIZE_W-1:0] req_size,
   input  logic                             req_batch_last,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic                             rsp_granted,
   output logic [fpba_pkg::SLOT_W-1:0]      rsp_chosen_block,
   output logic [fpba_pkg::PORT_SIZE_W-1:0] rsp_size_before,
   output logic [fpba_pkg::PORT_SIZE_W-1:0] rsp_size_left,
   output logic                             rsp_batch_done,
   output fpba_pkg::status_type             status
);
   import fpba_pkg::*;

   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W + 1;

   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [SIZE_WIDTH-1:0] size_ff, size_in;
   logic                  last_ff, last_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      pick_ff, pick_in;
   logic [SIZE_WIDTH-1:0] best_ff, best_in;
   logic                  found_ff, found_in;
   logic [NUM_BLOCKS-1:0] valid_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_granted_ff, rsp_granted_in;
   logic [SLOT_W-1:0]      rsp_chosen_ff, rsp_chosen_in;
   logic [PORT_SIZE_W-1:0] rsp_before_ff, rsp_before_in;
   logic [PORT_SIZE_W-1:0] rsp_left_ff, rsp_left_in;
   logic                   rsp_done_ff, rsp_done_in;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [SIZE_WIDTH-1:0] wr_data;
   logic [IDX_W-1:0]      rd_addr;
   logic [SIZE_WIDTH-1:0] rd_data;

   logic [SIZE_WIDTH-1:0] entry;
   logic                  fits;
   logic                  hit;
   logic [CMP_W-1:0]      slot_ext;
   logic                  slot_ok;
   logic                  out_free;

   fpba_ram #(
      .WIDTH (SIZE_WIDTH),
      .DEPTH (NUM_BLOCKS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Blocks never written since reset read as empty.
   assign entry    = valid_ff[idx_ff] ? rd_data : '0;
   assign fits     = (entry >= size_ff);
   assign slot_ext = CMP_W'(slot_ff);
   assign slot_ok  = (slot_ext < CMP_W'(NUM_BLOCKS));
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign status.accept    = accept;
   assign status.kind      = req_kind;
   assign status.scan_last = (idx_ff == last_idx);
   assign status.out_free  = out_free;

   always_comb begin
      slot_in  = slot_ff;
      size_in  = size_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      pick_in  = pick_ff;
      best_in  = best_ff;
      found_in = found_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_chosen_in  = rsp_chosen_ff;
      rsp_before_in  = rsp_before_ff;
      rsp_left_in    = rsp_left_ff;
      rsp_done_in    = rsp_done_ff;

      wr_en   = 1'b0;
      wr_addr = pick_ff;
      wr_data = best_ff - size_ff;
      rd_addr = '0;
      hit     = (policy == POL_WORST) ? (best_ff >= size_ff) : found_ff;

      unique case (ctrl.op)
         OP_FETCH: begin
            if (accept) begin
               slot_in  = req_slot;
               size_in  = SIZE_WIDTH'(req_size);
               last_in  = req_batch_last;
               idx_in   = '0;
               pick_in  = '0;
               best_in  = '0;
               found_in = 1'b0;
            end
         end
         OP_LOAD: begin
            wr_en   = slot_ok;
            wr_addr = slot_ext[IDX_W-1:0];
            wr_data = size_ff;
         end
         OP_SCAN: begin
            idx_in  = idx_ff + 1'b1;
            rd_addr = idx_ff + 1'b1;
            unique case (policy)
               POL_FIRST: begin
                  if (!found_ff && fits) begin
                     found_in = 1'b1;
                     pick_in  = idx_ff;
                     best_in  = entry;
                  end
               end
               POL_BEST: begin
                  if (fits && (!found_ff || entry < best_ff)) begin
                     found_in = 1'b1;
                     pick_in  = idx_ff;
                     best_in  = entry;
                  end
               end
               POL_WORST: begin
                  if (idx_ff == '0 || entry > best_ff) begin
                     pick_in = idx_ff;
                     best_in = entry;
                  end
               end
               default: begin
               end
            endcase
         end
         OP_DECIDE: begin
            if (out_free) begin
               wr_en          = hit;
               rsp_valid_in   = 1'b1;
               rsp_granted_in = hit;
               rsp_chosen_in  = hit ? SLOT_W'(pick_ff) : '0;
               rsp_before_in  = hit ? PORT_SIZE_W'(best_ff) : '0;
               rsp_left_in    = hit ? PORT_SIZE_W'(best_ff - size_ff) : '0;
               rsp_done_in    = last_ff;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff        <= slot_in;
      size_ff        <= size_in;
      last_ff        <= last_in;
      idx_ff         <= idx_in;
      pick_ff        <= pick_in;
      best_ff        <= best_in;
      found_ff       <= found_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_chosen_ff  <= rsp_chosen_in;
      rsp_before_ff  <= rsp_before_in;
      rsp_left_ff    <= rsp_left_in;
      rsp_done_ff    <= rsp_done_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_chosen_block = rsp_chosen_ff;
   assign rsp_size_before  = rsp_before_ff;
   assign rsp_size_left    = rsp_left_ff;
   assign rsp_batch_done   = rsp_done_ff;

endmodule
